@@ src/vhrs_pkg.sv @@
// ----------------------------------------------------------------------------
// vhrs_pkg
// Shared types and constants for the value histogram with running sum.
// ----------------------------------------------------------------------------
package vhrs_pkg;

  localparam int FIELD_W     = 16;
  localparam int VALUE_BITS  = 16;
  localparam int MAX_ITEMS   = 1048575;
  localparam int TABLE_DEPTH = 1 << VALUE_BITS;
  localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W       = 37;
  localparam int OUT_SUM_W   = 36;
  localparam int PROD_W      = VALUE_BITS + COUNT_W + 2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_REPLACE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] running_sum;
    logic                 dropped;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr;        // clear one table entry
    logic start;      // latch transaction, read old entry
    logic fetch_rep;  // capture old count, form product, read new entry
    logic add_rep;    // write merged count into new entry
    logic fin_ins;    // finish insert, load result
    logic fin_rep;    // zero old entry, update sum, load result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic opcode;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/vhrs_datapath.sv @@
// ----------------------------------------------------------------------------
// vhrs_datapath
// Count table memory, running sum, item total and output register.
// ----------------------------------------------------------------------------
module vhrs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  vhrs_pkg::dp_cmd_t   cmd,
  output vhrs_pkg::dp_status_t status,
  input  vhrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vhrs_pkg::out_item_t out_data
);
  import vhrs_pkg::*;

  logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] rdata;

  logic                  mem_we;
  logic [VALUE_BITS-1:0] mem_waddr;
  logic [COUNT_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [VALUE_BITS-1:0] mem_raddr;

  logic [VALUE_BITS-1:0] clr_addr;
  logic                  op;
  logic [VALUE_BITS-1:0] old_idx;
  logic [VALUE_BITS-1:0] new_idx;
  logic [COUNT_W-1:0]    cnt_old;
  logic                  do_move;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [VALUE_BITS:0] diff;

  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] total;
  logic               full;

  assign full = (total >= COUNT_W'(MAX_ITEMS));
  assign diff = $signed({1'b0, new_idx}) - $signed({1'b0, old_idx});
  assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, rdata}));

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = old_idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = in_data.value[VALUE_BITS-1:0];
    if (cmd.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end
    if (cmd.start) begin
      mem_re = 1'b1;
    end
    if (cmd.fetch_rep) begin
      mem_re    = 1'b1;
      mem_raddr = new_idx;
    end
    if (cmd.add_rep) begin
      mem_we    = do_move;
      mem_waddr = new_idx;
      mem_wdata = rdata + cnt_old;
    end
    if (cmd.fin_ins) begin
      mem_we    = !full;
      mem_wdata = rdata + COUNT_W'(1);
    end
    if (cmd.fin_rep) begin
      mem_we = do_move;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= count_mem[mem_raddr];
    end
  end

  always_comb begin
    sum_next = sum;
    if (cmd.fin_ins && !full) begin
      sum_next = sum + SUM_W'(old_idx);
    end
    if (cmd.fin_rep && do_move) begin
      sum_next = sum + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      sum       <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + VALUE_BITS'(1);
      end
      sum <= sum_next;
      if (cmd.fin_ins && !full) begin
        total <= total + COUNT_W'(1);
      end
      if (cmd.fin_ins || cmd.fin_rep) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op      <= in_data.opcode;
      old_idx <= in_data.value[VALUE_BITS-1:0];
      new_idx <= in_data.new_value[VALUE_BITS-1:0];
    end
    if (cmd.fetch_rep) begin
      cnt_old <= rdata;
      do_move <= (old_idx != new_idx) && (rdata != '0);
      prod    <= prod_next;
    end
    if (cmd.fin_ins || cmd.fin_rep) begin
      out_data.running_sum <= sum_next[OUT_SUM_W-1:0];
      out_data.dropped     <= cmd.fin_ins && full;
    end
  end

  assign status.opcode     = op;
  assign status.clear_last = &clr_addr;
  assign status.out_free   = !out_valid || out_ready;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= COUNT_W'(MAX_ITEMS))
    else $error("item total above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_ins && !full |=> total == $past(total) + COUNT_W'(1))
    else $error("accepted insert did not bump item total");

  a_rep_nomove: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_rep && !do_move |=> sum == $past(sum))
    else $error("replace without move changed the sum");

endmodule

@@ src/vhrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// vhrs_ctrl
// Sequencer: clearing pass after reset, then insert and replace steps.
// ----------------------------------------------------------------------------
module vhrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vhrs_pkg::dp_status_t status,
  output vhrs_pkg::dp_cmd_t    cmd
);
  import vhrs_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status.opcode == OP_REPLACE) begin
          cmd.fetch_rep = 1'b1;
          state_next    = ST_ADD;
        end else if (status.out_free) begin
          cmd.fin_ins = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_ADD: begin
        cmd.add_rep = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.fin_rep = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_FETCH)
    else $error("accepted transaction did not start a fetch");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != ST_CLEAR |=> state != ST_CLEAR)
    else $error("clearing pass re-entered outside reset");

endmodule

@@ src/value_histogram_remap_sum_top.sv @@
// pacing: a transaction is taken only in idle, after the previous one has loaded
//   its result, which waits for a free output register; an insert reads then writes
//   one count table entry, a replace reads and writes two
// reset: synchronous; afterwards a clearing pass zeroes all 65536 table entries,
//   one entry a cycle, during which in_ready stays low
// ----------------------------------------------------------------------------
// value_histogram_remap_sum_top
// Per-value count table with item total and running sum of stored values.
// ----------------------------------------------------------------------------
module value_histogram_remap_sum_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vhrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vhrs_pkg::out_item_t out_data
);
  import vhrs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vhrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vhrs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_value_histogram_remap_sum_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_value_histogram_remap_sum_top
// Sends inserts and replaces into the value histogram. Each returned sum and
// drop flag is checked against a local count table and running sum that are
// updated on every accepted transaction. Covers value extremes, replace
// corner cases, random mixes with idle bursts, output back-pressure, and a
// full-rate tail.
// ----------------------------------------------------------------------------
module tb_value_histogram_remap_sum_top;
  import vhrs_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE    = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  value_histogram_remap_sum_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the histogram state
  bit [COUNT_W-1:0] hist_count [TABLE_DEPTH];
  bit [SUM_W-1:0]   model_sum;
  bit [COUNT_W-1:0] model_total;

  out_item_t sum_expect_q [$];

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit hold_req     = 1'b0;

  int err_count = 0;
  int n_insert  = 0;
  int n_replace = 0;
  int n_results = 0;

  function automatic out_item_t histogram_update(input in_item_t item);
    bit [VALUE_BITS-1:0] src_v;
    bit [VALUE_BITS-1:0] dst_v;
    bit [COUNT_W-1:0]    moved;
    out_item_t           res;
    src_v = item.value[VALUE_BITS-1:0];
    dst_v = item.new_value[VALUE_BITS-1:0];
    res   = '0;
    if (item.opcode == OP_INSERT) begin
      if (model_total >= MAX_ITEMS) begin
        res.dropped = 1'b1;
      end else begin
        hist_count[src_v] += 1'b1;
        model_total       += 1'b1;
        model_sum          = SUM_W'(64'(model_sum) + 64'(src_v));
      end
    end else begin
      moved = hist_count[src_v];
      if (src_v != dst_v && moved != 0) begin
        model_sum = SUM_W'(64'(model_sum) + 64'(dst_v) * 64'(moved)
                           - 64'(src_v) * 64'(moved));
        hist_count[dst_v] += moved;
        hist_count[src_v]  = '0;
      end
    end
    res.running_sum = model_sum[OUT_SUM_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // valid stays high after acceptance so back-to-back transactions need no gap
  task automatic send_item(input logic op, input logic [FIELD_W-1:0] v,
                           input logic [FIELD_W-1:0] nv);
    in_item_t item;
    item.opcode    = op;
    item.value     = v;
    item.new_value = nv;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sum_expect_q = {sum_expect_q, histogram_update(item)};
    if (op == OP_INSERT) n_insert++;
    else n_replace++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sum_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_insert_extremes();
    send_item(OP_INSERT, 16'h0000, 16'h0000);
    send_item(OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_item(OP_INSERT, 16'hAAAA, 16'h5555);
    send_item(OP_INSERT, 16'h5555, 16'hAAAA);
    send_item(OP_INSERT, 16'hFFFF, 16'h0000);
    send_item(OP_INSERT, 16'h0007, 16'hFFFF);
    send_item(OP_INSERT, 16'hAAAA, 16'h0000);
    wait_idle();
  endtask

  task automatic test_replace_cases();
    // old value never stored
    send_item(OP_REPLACE, 16'h1234, 16'h4321);
    // old equals new leaves the count alone
    send_item(OP_REPLACE, 16'hFFFF, 16'hFFFF);
    send_item(OP_REPLACE, 16'hAAAA, 16'h5555);
    send_item(OP_REPLACE, 16'hAAAA, 16'h5555);
    send_item(OP_REPLACE, 16'h5555, 16'hFFFF);
    send_item(OP_REPLACE, 16'hFFFF, 16'h0000);
    send_item(OP_REPLACE, 16'h0000, 16'hFFFF);
    send_item(OP_REPLACE, 16'h0007, 16'h0000);
    send_item(OP_INSERT,  16'h0007, 16'h1234);
    send_item(OP_REPLACE, 16'h0000, 16'h0000);
    wait_idle();
  endtask

  task automatic test_random_mix();
    logic [FIELD_W-1:0] pool [POOL_SIZE];
    logic [FIELD_W-1:0] nv;
    int                 pick;
    int                 slot;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = FIELD_W'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (pick < 40) begin
        send_item(OP_INSERT, pool[slot], FIELD_W'($urandom));
      end else if (pick < 50) begin
        send_item(OP_INSERT, FIELD_W'($urandom), FIELD_W'($urandom));
      end else if (pick < 80) begin
        send_item(OP_REPLACE, pool[slot], pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (pick < 93) begin
        // move a pooled value somewhere new and keep tracking it
        nv = FIELD_W'($urandom);
        send_item(OP_REPLACE, pool[slot], nv);
        pool[slot] = nv;
      end else begin
        send_item(OP_REPLACE, FIELD_W'($urandom), FIELD_W'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2)
        send_item(OP_REPLACE, FIELD_W'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 3)));
      else
        send_item(OP_INSERT, FIELD_W'($urandom_range(0, 3)), FIELD_W'($urandom));
    end
    wait_idle();
    src_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(OP_REPLACE, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom_range(0, 7)));
      else
        send_item(OP_INSERT, FIELD_W'($urandom_range(0, 7)), FIELD_W'($urandom));
    end
    wait_idle();
  endtask

  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (sum_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, sum=%0d dropped=%0b",
                                  out_data.running_sum, out_data.dropped));
      end else begin
        want = sum_expect_q.pop_front();
        if (out_data.running_sum !== want.running_sum)
          report_mismatch($sformatf("running_sum got %0d want %0d",
                                    out_data.running_sum, want.running_sum));
        if (out_data.dropped !== want.dropped)
          report_mismatch($sformatf("dropped got %0b want %0b",
                                    out_data.dropped, want.dropped));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_insert_extremes();
    test_replace_cases();
    test_random_mix();
    test_backpressure();
    // final stretch runs at full rate on both sides
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_full_rate();
    wait_idle();
    $display("run covered %0d inserts and %0d replaces, with idle bursts,",
             n_insert, n_replace);
    $display("a long output stall and a full-rate tail; %0d results checked, %0d mismatches",
             n_results, err_count);
    if (err_count == 0) begin
      $display("PASS value_histogram_remap_sum_top");
    end else begin
      $display("FAIL value_histogram_remap_sum_top");
    end
    $finish;
  end

  // clearing pass plus all traffic under the longest stalls stays far below this
  initial begin
    #20_000_000;
    $display("timeout waiting for transactions");
    $display("FAIL value_histogram_remap_sum_top");
    $finish;
  end

endmodule
